### hdl/lfs_pkg.sv
package lfs_pkg;

  localparam int MaxRecord = 4096;
  localparam int IdxW      = $clog2(MaxRecord) + 1;
  localparam int StartW    = 12;
  localparam int StepW     = 32;
  localparam int SampleW   = 32;
  localparam int SumIW     = 24;
  localparam int SumSqW    = 36;
  localparam int SumVW     = 44;
  localparam int SumIvW    = 56;
  localparam int NumW      = 70;
  localparam int AccW      = 104;
  localparam int DvdW      = NumW + 32;
  localparam int SlopeW    = 64;
  localparam int MulSteps  = 32;
  localparam int CntW      = 7;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;

  localparam logic [StepW-1:0] XStepReset = 32'h0001_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgXStep = 2'd0,
    CfgStart = 2'd1,
    CfgEnd   = 2'd2
  } lfs_cfg_e;

  // one finished window handed from the accumulator to the solver
  typedef struct packed {
    logic [SumIW-1:0]         sum_index;
    logic [SumSqW-1:0]        sum_sq;
    logic signed [SumVW-1:0]  sum_val;
    logic signed [SumIvW-1:0] sum_iv;
    logic [IdxW-1:0]          n;
    logic [StepW-1:0]         x_step;
    logic                     short_fit;
  } lfs_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lfs_q_stat_t;

endpackage

### hdl/lfs_front.sv
module lfs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lfs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lfs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [lfs_pkg::SampleW-1:0] sample_i,
  input  logic                         restart_i,
  input  lfs_pkg::lfs_q_stat_t         q_stat_i,
  output logic                         push_o,
  output lfs_pkg::lfs_job_t            job_o
);
  import lfs_pkg::*;

  logic [StepW-1:0]         x_step_q;
  logic [StartW-1:0]        start_q;
  logic [IdxW-1:0]          end_q;
  logic [IdxW-1:0]          index_q, index_d;
  logic [SumIW-1:0]         sum_i_q, sum_i_d;
  logic [SumSqW-1:0]        sum_sq_q, sum_sq_d;
  logic signed [SumVW-1:0]  sum_v_q, sum_v_d;
  logic signed [SumIvW-1:0] sum_iv_q, sum_iv_d;

  logic                     accept;
  logic [IdxW-1:0]          idx, end_eff, start_x;
  logic                     in_win, emit;
  logic signed [IdxW+SampleW:0] prod;
  logic [2*IdxW-1:0]        sq;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_stat_i.full;
  assign accept      = in_valid_i && in_ready_o;

  assign idx     = restart_i ? '0 : index_q;
  assign index_d = (idx < IdxW'(MaxRecord)) ? idx + 1'b1 : IdxW'(MaxRecord);
  assign end_eff = (end_q < IdxW'(MaxRecord)) ? end_q : IdxW'(MaxRecord);
  assign start_x = IdxW'(start_q);
  assign in_win  = (idx >= start_x) && (idx < end_eff);
  assign emit    = (end_eff != '0) && (start_x < end_eff) && (idx == end_eff - 1'b1);

  assign prod = $signed({1'b0, idx}) * sample_i;
  assign sq   = idx * idx;

  always_comb begin
    sum_i_d  = restart_i ? '0 : sum_i_q;
    sum_sq_d = restart_i ? '0 : sum_sq_q;
    sum_v_d  = restart_i ? '0 : sum_v_q;
    sum_iv_d = restart_i ? '0 : sum_iv_q;
    if (in_win) begin
      sum_i_d  = sum_i_d + SumIW'(idx);
      sum_sq_d = sum_sq_d + SumSqW'(sq);
      sum_v_d  = sum_v_d + {{(SumVW-SampleW){sample_i[SampleW-1]}}, sample_i};
      sum_iv_d = sum_iv_d + {{(SumIvW-IdxW-SampleW-1){prod[IdxW+SampleW]}}, prod};
    end
  end

  assign push_o           = accept && emit;
  assign job_o.sum_index  = sum_i_d;
  assign job_o.sum_sq     = sum_sq_d;
  assign job_o.sum_val    = sum_v_d;
  assign job_o.sum_iv     = sum_iv_d;
  assign job_o.n          = end_eff - start_x;
  assign job_o.x_step     = x_step_q;
  assign job_o.short_fit  = (end_eff - start_x) < IdxW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_step_q <= XStepReset;
      start_q  <= '0;
      end_q    <= IdxW'(MaxRecord);
      index_q  <= '0;
      sum_i_q  <= '0;
      sum_sq_q <= '0;
      sum_v_q  <= '0;
      sum_iv_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (lfs_cfg_e'(cfg_index_i))
          CfgXStep: x_step_q <= cfg_data_i;
          CfgStart: start_q  <= cfg_data_i[StartW-1:0];
          CfgEnd:   end_q    <= cfg_data_i[IdxW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        index_q  <= index_d;
        sum_i_q  <= sum_i_d;
        sum_sq_q <= sum_sq_d;
        sum_v_q  <= sum_v_d;
        sum_iv_q <= sum_iv_d;
      end
    end
  end

endmodule

### hdl/lfs_queue.sv
module lfs_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lfs_pkg::lfs_job_t    job_i,
  input  logic                 pop_i,
  output lfs_pkg::lfs_job_t    job_o,
  output lfs_pkg::lfs_q_stat_t stat_o
);
  import lfs_pkg::*;

  lfs_job_t   slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign job_o        = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### hdl/lfs_back.sv
module lfs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfs_pkg::lfs_q_stat_t          q_stat_i,
  input  lfs_pkg::lfs_job_t             job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [lfs_pkg::SlopeW-1:0] slope_o,
  output logic                          fit_valid_o
);
  import lfs_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StDiv  = 5'b00100,
    StFix  = 5'b01000,
    StDone = 5'b10000
  } lfs_state_e;

  lfs_state_e        state_q;
  lfs_job_t          job_q;
  logic [2:0]        op_q;
  logic [CntW-1:0]   cnt_q;
  logic [AccW-1:0]   acc_q, mcand_q, acc_d;
  logic [StepW-1:0]  mplier_q;
  logic [NumW-1:0]   num_q, num_abs;
  logic [AccW-1:0]   den_abs;
  logic [DvdW-1:0]   dvd_q;
  logic [AccW-1:0]   rem_q, dsr_q, r_sh;
  logic              ge;
  logic [SlopeW-1:0] quo_q, res_q, mag, fixed;
  logic              big_q, neg_q, fit_q, sat;
  logic              out_valid_q, fit_out_q;
  logic [SlopeW-1:0] slope_out_q;

  assign pop_o   = (state_q == StIdle) && !q_stat_i.empty;
  assign acc_d   = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign num_abs = num_q[NumW-1] ? -num_q : num_q;
  assign den_abs = acc_d[AccW-1] ? -acc_d : acc_d;
  assign r_sh    = {rem_q[AccW-2:0], dvd_q[DvdW-1]};
  assign ge      = r_sh >= dsr_q;

  always_comb begin
    if (neg_q) begin
      sat   = big_q || (quo_q[SlopeW-1] && (quo_q[SlopeW-2:0] != '0));
      mag   = sat ? {1'b1, {(SlopeW-1){1'b0}}} : quo_q;
      fixed = -mag;
    end else begin
      sat   = big_q || quo_q[SlopeW-1];
      mag   = quo_q;
      fixed = sat ? {1'b0, {(SlopeW-1){1'b1}}} : quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (!q_stat_i.empty) begin
            job_q    <= job_i;
            op_q     <= 3'd0;
            cnt_q    <= '0;
            acc_q    <= '0;
            mcand_q  <= {{(AccW-SumIvW){job_i.sum_iv[SumIvW-1]}}, job_i.sum_iv};
            mplier_q <= StepW'(job_i.n);
            res_q    <= '0;
            fit_q    <= 1'b0;
            state_q  <= job_i.short_fit ? StDone : StMul;
          end
        end
        StMul: begin
          acc_q    <= acc_d;
          mcand_q  <= {mcand_q[AccW-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[StepW-1:1]};
          cnt_q    <= cnt_q + 1'b1;
          if (cnt_q == CntW'(MulSteps - 1)) begin
            cnt_q <= '0;
            op_q  <= op_q + 3'd1;
            case (op_q)
              3'd0: begin
                // subtract sx*sy from n*sxy
                mcand_q  <= -{{(AccW-SumVW){job_q.sum_val[SumVW-1]}}, job_q.sum_val};
                mplier_q <= StepW'(job_q.sum_index);
              end
              3'd1: begin
                num_q    <= acc_d[NumW-1:0];
                acc_q    <= '0;
                mcand_q  <= AccW'(job_q.sum_sq);
                mplier_q <= StepW'(job_q.n);
              end
              3'd2: begin
                mcand_q  <= -AccW'(job_q.sum_index);
                mplier_q <= StepW'(job_q.sum_index);
              end
              3'd3: begin
                acc_q    <= '0;
                mcand_q  <= acc_d;
                mplier_q <= job_q.x_step;
              end
              default: begin
                if (acc_d == '0) begin
                  state_q <= StDone;
                end else begin
                  neg_q   <= num_q[NumW-1] ^ acc_d[AccW-1];
                  dvd_q   <= {num_abs, 32'b0};
                  dsr_q   <= den_abs;
                  rem_q   <= '0;
                  quo_q   <= '0;
                  big_q   <= 1'b0;
                  state_q <= StDiv;
                end
              end
            endcase
          end
        end
        StDiv: begin
          rem_q <= ge ? r_sh - dsr_q : r_sh;
          dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
          quo_q <= {quo_q[SlopeW-2:0], ge};
          big_q <= big_q | quo_q[SlopeW-1];
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DvdW - 1)) state_q <= StFix;
        end
        StFix: begin
          res_q   <= fixed;
          fit_q   <= 1'b1;
          state_q <= StDone;
        end
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            slope_out_q <= res_q;
            fit_out_q   <= fit_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign slope_o     = slope_out_q;
  assign fit_valid_o = fit_out_q;

endmodule

### hdl/linear_fit_slope.sv
// a closing window reaches the queue at its accepting edge; the solver pops it when idle, sends a
// window of under two points straight to the output, stops after the multiplies on a zero denominator,
// and otherwise divides and saturates; one sample per cycle until the two-deep queue fills; the solver
// takes one window at a time through the bit-serial multiplier (5 x 32 steps) and restoring divider (102 steps)
// reset: rst_ni asynchronous active low; x_step = 1.0, start_index = 0,
// end_index = 4096, sample index and all sums cleared
module linear_fit_slope (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lfs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lfs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [lfs_pkg::SampleW-1:0] sample_i,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [lfs_pkg::SlopeW-1:0] slope_o,
  output logic                         fit_valid_o
);
  import lfs_pkg::*;

  // window handed from accumulator to solver
  lfs_job_t    push_job, pop_job;
  lfs_q_stat_t q_stat;
  logic        push, pop;

  // front: config registers, index counter and window sums
  lfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .restart_i   (restart_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  // two-deep queue so sampling carries on while the solver is busy
  lfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .stat_o (q_stat)
  );

  // back: serial multiplies for numerator and denominator, divide, saturate
  lfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .slope_o     (slope_o),
    .fit_valid_o (fit_valid_o)
  );

  // never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_stat.full |-> !push)
    else $error("push into full queue");

  // never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  // an undefined fit always carries a zero slope
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !fit_valid_o) |-> (slope_o == '0))
    else $error("invalid fit with nonzero slope");

endmodule
